@@ sv/spq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the stable priority queue: operation and
// status codes, field widths and the control state encoding.
// ----------------------------------------------------------------------------
package spq_pkg;

  // default sizing
  localparam int DEPTH_DEF    = 16;
  localparam int TAG_BITS_DEF = 16;

  // request and result field widths
  localparam int IN_TAG_W = 16;
  localparam int KIND_W   = 8;
  localparam int PRIO_W   = 16;
  localparam int CNT_W    = 5;
  localparam int STAT_W   = 2;

  // packed stream widths
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  // operation codes (in_tuser)
  localparam logic FN_INSERT = 1'b0;
  localparam logic FN_REMOVE = 1'b1;

  // status codes (out_tuser)
  typedef logic [STAT_W-1:0] status_t;
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_BADTAG = 2'd1;
  localparam status_t ST_FULL   = 2'd2;
  localparam status_t ST_EMPTY  = 2'd3;

  // control sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_POP,
    S_DONE
  } state_t;

endpackage

@@ sv/spq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/stable_priority_queue.sv @@
`timescale 1ns / 1ps
// An insert scans every entry, then moves the entries that go behind it back one by one,
// last entry first; a duplicate or full reject ends after the scan. A remove reads the
// head entry; a remove on an empty queue and a zero tag go straight to the result.
// One request at a time; the next is taken while a result waits at the output.
// Reset (rst_n low, synchronous) empties the queue; no RAM clearing pass.
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue kept sorted in a circular RAM buffer, lowest
// priority first, equal priorities in arrival order.
// ----------------------------------------------------------------------------
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // tag[15:0], kind[23:16], priority_req[39:24]
  input  logic                  in_tuser,   // func[0]
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // count[4:0], out_tag[20:5], out_kind[28:21],
                                            // out_priority[44:29], zero[47:45]
  output logic [STAT_W-1:0]     out_tuser   // status[1:0]
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = TAG_BITS + KIND_W + PRIO_W;

  // logical position to RAM address, relative to the head
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(l);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // control state
  state_t                   state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [AW-1:0]            head_r, head_nxt;
  logic                     pend_r, pend_nxt;
  logic                     out_valid_r, out_valid_nxt;

  // request and working payload
  logic [TAG_BITS-1:0]      req_tag_r, req_tag_nxt;
  logic [KIND_W-1:0]        req_kind_r, req_kind_nxt;
  logic signed [PRIO_W-1:0] req_prio_r, req_prio_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic [CW-1:0]            pend_idx_r, pend_idx_nxt;
  logic [CW-1:0]            pos_r, pos_nxt;
  logic                     dup_r, dup_nxt;
  status_t                  res_status_r, res_status_nxt;
  logic [TAG_BITS-1:0]      res_tag_r, res_tag_nxt;
  logic [KIND_W-1:0]        res_kind_r, res_kind_nxt;
  logic [PRIO_W-1:0]        res_prio_r, res_prio_nxt;
  logic [OUT_DATA_W-1:0]    out_data_r, out_data_nxt;
  status_t                  out_user_r, out_user_nxt;

  // RAM port
  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [EW-1:0]            ram_wdata, ram_rdata;

  // decoded request and read entry
  logic                     accept;
  logic [31:0]              in_tag32;
  logic [TAG_BITS-1:0]      in_tag;
  logic [TAG_BITS-1:0]      rd_tag;
  logic [KIND_W-1:0]        rd_kind;
  logic signed [PRIO_W-1:0] rd_prio;
  logic                     scan_issue, scan_end, sh_issue, sh_end, out_free;
  logic [31:0]              cnt32, tag32;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_tag32  = 32'(in_tdata[15:0]);
  assign in_tag    = in_tag32[TAG_BITS-1:0];

  assign rd_tag  = ram_rdata[TAG_BITS-1:0];
  assign rd_kind = ram_rdata[TAG_BITS +: KIND_W];
  assign rd_prio = $signed(ram_rdata[TAG_BITS+KIND_W +: PRIO_W]);

  assign scan_issue = (state_r == S_SCAN) && (idx_r < count_r);
  assign scan_end   = (state_r == S_SCAN) && !scan_issue && !pend_r;
  assign sh_issue   = (state_r == S_SHIFT) && (idx_r > pos_r);
  assign sh_end     = (state_r == S_SHIFT) && !sh_issue && !pend_r;
  assign out_free   = !out_valid_r || out_tready;

  assign cnt32 = 32'(count_r);
  assign tag32 = 32'(res_tag_r);

  spq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_spq_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_tuser == FN_REMOVE) begin
            state_nxt = (count_r == '0) ? S_DONE : S_POP;
          end else begin
            state_nxt = (in_tag == '0) ? S_DONE : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = (dup_r || count_r == CW'(DEPTH)) ? S_DONE : S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sh_end) begin
          state_nxt = S_DONE;
        end
      end
      S_POP: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath, RAM access and result staging
  always_comb begin
    count_nxt      = count_r;
    head_nxt       = head_r;
    pend_nxt       = 1'b0;
    req_tag_nxt    = req_tag_r;
    req_kind_nxt   = req_kind_r;
    req_prio_nxt   = req_prio_r;
    idx_nxt        = idx_r;
    pend_idx_nxt   = pend_idx_r;
    pos_nxt        = pos_r;
    dup_nxt        = dup_r;
    res_status_nxt = res_status_r;
    res_tag_nxt    = res_tag_r;
    res_kind_nxt   = res_kind_r;
    res_prio_nxt   = res_prio_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        // latch request, start head read for a remove on a nonempty queue
        if (accept) begin
          req_tag_nxt    = in_tag;
          req_kind_nxt   = in_tdata[23:16];
          req_prio_nxt   = $signed(in_tdata[39:24]);
          idx_nxt        = '0;
          pos_nxt        = '0;
          dup_nxt        = 1'b0;
          res_status_nxt = ST_OK;
          res_tag_nxt    = '0;
          res_kind_nxt   = '0;
          res_prio_nxt   = '0;
          if (in_tuser == FN_REMOVE) begin
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head_r;
            end
          end else if (in_tag == '0) begin
            res_status_nxt = ST_BADTAG;
          end
        end
      end
      S_SCAN: begin
        // walk all entries: look for the tag, count those not behind the new one
        if (scan_issue) begin
          ram_re    = 1'b1;
          ram_raddr = phys(head_r, idx_r);
          idx_nxt   = idx_r + CW'(1);
          pend_nxt  = 1'b1;
        end
        if (pend_r) begin
          if (rd_tag == req_tag_r) begin
            dup_nxt = 1'b1;
          end
          if (rd_prio <= req_prio_r) begin
            pos_nxt = pos_r + CW'(1);
          end
        end
        if (scan_end) begin
          if (dup_r) begin
            res_status_nxt = ST_BADTAG;
          end else if (count_r == CW'(DEPTH)) begin
            res_status_nxt = ST_FULL;
          end else begin
            idx_nxt = count_r;
          end
        end
      end
      S_SHIFT: begin
        // move the tail back by one, last entry first, then place the new one
        if (sh_issue) begin
          ram_re       = 1'b1;
          ram_raddr    = phys(head_r, idx_r - CW'(1));
          idx_nxt      = idx_r - CW'(1);
          pend_idx_nxt = idx_r - CW'(1);
          pend_nxt     = 1'b1;
        end
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = phys(head_r, pend_idx_r + CW'(1));
          ram_wdata = ram_rdata;
        end
        if (sh_end) begin
          ram_we    = 1'b1;
          ram_waddr = phys(head_r, pos_r);
          ram_wdata = {req_prio_r, req_kind_r, req_tag_r};
          count_nxt = count_r + CW'(1);
        end
      end
      S_POP: begin
        // take the head entry and advance the head
        res_tag_nxt  = rd_tag;
        res_kind_nxt = rd_kind;
        res_prio_nxt = rd_prio;
        head_nxt     = phys(head_r, CW'(1));
        count_nxt    = count_r - CW'(1);
      end
      S_DONE: begin
        // hand the result to the output register once it is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = res_status_r;
          out_data_nxt  = {3'b000, res_prio_r, res_kind_r, tag32[15:0], cnt32[CNT_W-1:0]};
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_tag_r    <= req_tag_nxt;
    req_kind_r   <= req_kind_nxt;
    req_prio_r   <= req_prio_nxt;
    idx_r        <= idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    pos_r        <= pos_nxt;
    dup_r        <= dup_nxt;
    res_status_r <= res_status_nxt;
    res_tag_r    <= res_tag_nxt;
    res_kind_r   <= res_kind_nxt;
    res_prio_r   <= res_prio_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ sv/spq_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_chk
// Port-level checks of the stable priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_chk
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [STAT_W-1:0]     out_tuser
);

  // no result pending right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // an empty remove reports nothing and an empty queue
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |-> out_tdata[44:0] == '0)
    else $error("empty result with nonzero fields");

  // a full reject reports a full queue
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |-> (DEPTH > 31) || out_tdata[4:0] == 5'(DEPTH))
    else $error("full status with count below depth");

  // the count never exceeds the depth
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (DEPTH > 31) || out_tdata[4:0] <= 5'(DEPTH))
    else $error("count above depth");

endmodule

bind stable_priority_queue spq_chk #(.DEPTH(DEPTH)) u_spq_chk (.*);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stable_priority_queue. A driver sends insert and
// remove requests from a prefilled list, a monitor takes the results, and a
// behavioral copy of the sorted queue predicts every result as its request
// is accepted. Both sides idle in random bursts. The receiver holds off long
// enough to back up the input. The sender once waits for all results to
// come home.
// ----------------------------------------------------------------------------
module tb;
  import spq_pkg::*;

  localparam int QDEPTH = DEPTH_DEF;

  // one request as the driver sends it
  typedef struct {
    logic                     func;
    logic [IN_TAG_W-1:0]      tag;
    logic [KIND_W-1:0]        kind;
    logic signed [PRIO_W-1:0] prio;
    bit                       wait_drain;
  } queue_req_t;

  // one result as the block returns it
  typedef struct {
    status_t                  status;
    logic [CNT_W-1:0]         count;
    logic [IN_TAG_W-1:0]      tag;
    logic [KIND_W-1:0]        kind;
    logic signed [PRIO_W-1:0] prio;
  } queue_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // tag[15:0], kind[23:16], priority_req[39:24]
  logic                  in_tuser = 1'b0; // func[0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // count[4:0], out_tag[20:5], out_kind[28:21],
                                          // out_priority[44:29], zero[47:45]
  logic [STAT_W-1:0]     out_tuser;       // status[1:0]

  // requests still to send, results still owed by the block
  queue_req_t    req_fifo[$];
  queue_result_t due_results[$];

  // behavioral copy of the queue contents
  logic [IN_TAG_W-1:0]      held_tag[QDEPTH];
  logic [KIND_W-1:0]        held_kind[QDEPTH];
  logic signed [PRIO_W-1:0] held_prio[QDEPTH];
  int                       held_count = 0;

  // run statistics
  int n_errors = 0;
  int n_results = 0;
  int n_sent = 0;
  int n_insert_ok = 0;
  int n_bad_tag = 0;
  int n_full = 0;
  int n_pop_ok = 0;
  int n_pop_empty = 0;
  int peak_count = 0;
  bit calm = 1'b0;

  stable_priority_queue uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Apply one request to the copy of the queue and return its result.
  function automatic queue_result_t apply_queue_op(queue_req_t r);
    queue_result_t res;
    int            i;
    int            pos;
    bit            dup;
    res = '{status: ST_OK, count: '0, tag: '0, kind: '0, prio: '0};
    dup = 1'b0;
    if (r.func == FN_INSERT) begin
      for (i = 0; i < held_count; i++)
        if (held_tag[i] == r.tag) dup = 1'b1;
      if (r.tag == '0 || dup) begin
        res.status = ST_BADTAG;
        n_bad_tag++;
      end else if (held_count >= QDEPTH) begin
        res.status = ST_FULL;
        n_full++;
      end else begin
        // go behind every entry of equal or smaller priority
        pos = 0;
        while (pos < held_count && held_prio[pos] <= r.prio) pos++;
        for (i = held_count; i > pos; i--) begin
          held_tag[i]  = held_tag[i-1];
          held_kind[i] = held_kind[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_tag[pos]  = r.tag;
        held_kind[pos] = r.kind;
        held_prio[pos] = r.prio;
        held_count++;
        n_insert_ok++;
        if (held_count > peak_count) peak_count = held_count;
      end
    end else if (held_count == 0) begin
      res.status = ST_EMPTY;
      n_pop_empty++;
    end else begin
      // hand out the head and close the gap
      res.tag  = held_tag[0];
      res.kind = held_kind[0];
      res.prio = held_prio[0];
      for (i = 1; i < held_count; i++) begin
        held_tag[i-1]  = held_tag[i];
        held_kind[i-1] = held_kind[i];
        held_prio[i-1] = held_prio[i];
      end
      held_count--;
      n_pop_ok++;
    end
    res.count = held_count[CNT_W-1:0];
    return res;
  endfunction

  task automatic add_req(logic func, int tag, int kind, int prio, bit wait_drain = 1'b0);
    queue_req_t r;
    r.func       = func;
    r.tag        = tag[IN_TAG_W-1:0];
    r.kind       = kind[KIND_W-1:0];
    r.prio       = prio[PRIO_W-1:0];
    r.wait_drain = wait_drain;
    req_fifo.push_back(r);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  // Driver: offer the head of the request list, predict on acceptance.
  always @(posedge clk) begin : request_driver
    int gap;
    bit offer;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        due_results.push_back(apply_queue_op(req_fifo[0]));
        void'(req_fifo.pop_front());
        n_sent++;
      end
      calm <= (req_fifo.size() <= 100);
      // keep a request on the bus until it is taken
      if (!(in_tvalid && !in_tready)) begin
        offer = 1'b0;
        if (gap > 0) begin
          gap--;
        end else if (req_fifo.size() > 0 &&
                     !(req_fifo[0].wait_drain && due_results.size() > 0)) begin
          if (!calm && $urandom_range(0, 9) == 0) gap = $urandom_range(0, 8);
          else offer = 1'b1;
        end
        in_tvalid <= offer;
        if (offer) begin
          in_tdata <= {req_fifo[0].prio, req_fifo[0].kind, req_fifo[0].tag};
          in_tuser <= req_fifo[0].func;
        end
      end
    end
  end

  // Monitor: check each result against the oldest prediction, pace out_tready.
  always @(posedge clk) begin : result_monitor
    int            stall;
    int            holdoff;
    bit            hold_done;
    bit            rdy;
    queue_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall = 0;
      holdoff = 0;
      hold_done = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (due_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual status %0d count %0d",
                   $time, out_tuser, out_tdata[4:0]);
          n_errors++;
        end else begin
          want = due_results.pop_front();
          check_field("status", want.status, out_tuser);
          check_field("count", want.count, out_tdata[4:0]);
          check_field("out_tag", want.tag, out_tdata[20:5]);
          check_field("out_kind", want.kind, out_tdata[28:21]);
          check_field("out_priority", want.prio, $signed(out_tdata[44:29]));
          check_field("pad", 0, out_tdata[47:45]);
        end
      end
      // one long hold-off to back the block up into its input
      if (!hold_done && n_results >= 200) begin
        holdoff = 80;
        hold_done = 1'b1;
      end
      if (holdoff > 0) begin
        holdoff--;
        rdy = 1'b0;
      end else if (stall > 0) begin
        stall--;
        rdy = 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall = $urandom_range(0, 8);
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_tready <= rdy;
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int blk;
    int k;
    int pct;
    int tag;
    int prio;
    int phase_pct[4];
    phase_pct = '{90, 20, 65, 40};

    // directed: empty remove, bad tags, extremes, ties, fill to full
    add_req(FN_REMOVE, 0, 0, 0);
    add_req(FN_INSERT, 0, 8'h5A, 7);
    add_req(FN_INSERT, 16'hFFFF, 8'hFF, 32767);
    add_req(FN_INSERT, 1, 0, -32768);
    add_req(FN_INSERT, 16'hFFFF, 3, 0);
    add_req(FN_INSERT, 2, 10, 5);
    add_req(FN_INSERT, 3, 11, 5);
    add_req(FN_INSERT, 4, 12, 5);
    for (k = 0; k < 11; k++)
      add_req(FN_INSERT, 100 + k, k, k * 3 - 15);
    add_req(FN_INSERT, 200, 1, -1);
    add_req(FN_INSERT, 2, 1, -1);
    for (k = 0; k < 4; k++)
      add_req(FN_REMOVE, 16'hFFFF, 8'hFF, -1);

    // random: phases that lean toward filling or draining
    for (blk = 0; blk < 15; blk++) begin
      pct = phase_pct[blk % 4];
      for (k = 0; k < 50; k++) begin
        case ($urandom_range(0, 19))
          0:       tag = 0;
          1, 2:    tag = $urandom_range(0, 65535);
          default: tag = $urandom_range(1, 24);
        endcase
        if ($urandom_range(0, 3) == 0) prio = $urandom_range(0, 65535);
        else prio = $urandom_range(0, 6) - 3;
        add_req(($urandom_range(0, 99) < pct) ? FN_INSERT : FN_REMOVE,
                tag, $urandom_range(0, 255), prio, blk == 8 && k == 0);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (req_fifo.size() > 0 || due_results.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Sent %0d requests: %0d inserts stored, %0d bad or duplicate tags, %0d full",
             n_sent, n_insert_ok, n_bad_tag, n_full);
    $display("Removes: %0d returned an entry, %0d on empty; peak fill %0d; %0d results",
             n_pop_ok, n_pop_empty, peak_count, n_results);
    if (n_errors == 0 && due_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("Timeout with %0d requests unsent and %0d results owed",
             req_fifo.size(), due_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
